/* src/scpa_pkg.sv */
// -----------------------------------------------------------------------------
// scpa_pkg
// Shared constants, codes and types for the size-class pool allocator.
// -----------------------------------------------------------------------------
package scpa_pkg;

   localparam int NUM_CLASSES     = 4;
   localparam int SLOTS_PER_CLASS = 256;
   localparam int ADDR_BITS       = 32;

   localparam int CLS_BITS  = $clog2(NUM_CLASSES);
   localparam int SLOT_BITS = $clog2(SLOTS_PER_CLASS);
   localparam int MEM_DEPTH = NUM_CLASSES * SLOTS_PER_CLASS;
   localparam int MEM_ABITS = CLS_BITS + SLOT_BITS;
   localparam int SIZE_BITS = 16;
   localparam int CNT_BITS  = 8;
   localparam int OFF_BITS  = SIZE_BITS + CNT_BITS;
   localparam int BASE_BITS = ADDR_BITS + 2;
   localparam int LIVE_BITS = 10;
   localparam int STAT_BITS = 3;

   // request modes
   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_FREE  = 1'b1;

   // result status codes
   localparam logic [STAT_BITS-1:0] ST_OK         = 3'd0;
   localparam logic [STAT_BITS-1:0] ST_TOO_LARGE  = 3'd1;
   localparam logic [STAT_BITS-1:0] ST_FULL       = 3'd2;
   localparam logic [STAT_BITS-1:0] ST_OUTSIDE    = 3'd3;
   localparam logic [STAT_BITS-1:0] ST_EMPTY      = 3'd4;
   localparam logic [STAT_BITS-1:0] ST_MISALIGNED = 3'd5;
   localparam logic [STAT_BITS-1:0] ST_DOUBLE     = 3'd6;

   // register indexes
   localparam logic [2:0] CSR_CLASSES  = 3'd0;
   localparam logic [2:0] CSR_CASCADE  = 3'd1;
   localparam logic [2:0] CSR_BASE     = 3'd2;
   localparam logic [2:0] CSR_SIZES    = 3'd3;
   localparam logic [2:0] CSR_COUNTS   = 3'd4;

   localparam logic [63:0] SIZES_RESET  = 64'd36029071898968080;
   localparam logic [31:0] COUNTS_RESET = 32'd1077952576;

   // stack memory access
   typedef struct packed {
      logic                 we;
      logic [MEM_ABITS-1:0] addr;
      logic [SLOT_BITS-1:0] wdata;
   } mem_req_type;

endpackage

/* src/scpa_if.sv */
// -----------------------------------------------------------------------------
// scpa_req_if / scpa_rsp_if
// Valid/ready channels for request and response words.
// -----------------------------------------------------------------------------
interface scpa_req_if;
   logic        valid;
   logic        ready;
   logic        mode;
   logic [15:0] request_size;
   logic [31:0] address;
   modport source (output valid, mode, request_size, address, input ready);
   modport sink   (input valid, mode, request_size, address, output ready);
endinterface

interface scpa_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [31:0] block_address;
   logic [1:0]  size_class;
   logic [15:0] block_size;
   logic [9:0]  live_allocations;
   logic [15:0] largest_free_size;
   modport source (output valid, status, block_address, size_class, block_size,
                   live_allocations, largest_free_size, input ready);
   modport sink   (input valid, status, block_address, size_class, block_size,
                   live_allocations, largest_free_size, output ready);
endinterface

/* src/size_class_pool_allocator_top.sv */
// -----------------------------------------------------------------------------
// size_class_pool_allocator_top
// Pool allocator over up to four fixed-size classes with LIFO free stacks.
// -----------------------------------------------------------------------------
// After reset the block loads the free stacks with their slot indexes and
// takes no word until that is done. Each word then runs to completion before
// the next is taken: the class bases are worked out first, an allocation then
// reads its slot from the stack and computes the block address, and a free
// that passes the divider walks the free slots of its class for the
// double-free check, through the single memory read port. A finished response
// sits in an output register, so a new word may be taken while it waits.
module size_class_pool_allocator_top (
   input  logic                 clock,
   input  logic                 reset,
   scpa_req_if.sink             req_ch,
   scpa_rsp_if.source           rsp_ch,
   input  logic                 csr_wr_en,
   input  logic [2:0]           csr_index,
   input  logic [63:0]          csr_wdata
);
   import scpa_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_BASE, S_DECIDE, S_AMUL, S_AADD, S_DIV, S_SCAN, S_PUSH, S_DONE
   } state_type;

   // configuration registers
   logic [2:0]           classes_ff;
   logic                 cascade_ff;
   logic [ADDR_BITS-1:0] heap_base_ff;
   logic [63:0]          sizes_ff;
   logic [31:0]          counts_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         classes_ff   <= 3'd4;
         cascade_ff   <= 1'b0;
         heap_base_ff <= '0;
         sizes_ff     <= SIZES_RESET;
         counts_ff    <= COUNTS_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_CLASSES: classes_ff   <= csr_wdata[2:0];
            CSR_CASCADE: cascade_ff   <= csr_wdata[0];
            CSR_BASE:    heap_base_ff <= csr_wdata[ADDR_BITS-1:0];
            CSR_SIZES:   sizes_ff     <= csr_wdata;
            CSR_COUNTS:  counts_ff    <= csr_wdata[31:0];
            default:     ;
         endcase
      end
   end

   logic [SIZE_BITS-1:0] esize  [NUM_CLASSES];
   logic [CNT_BITS-1:0]  ecount [NUM_CLASSES];
   logic [CLS_BITS:0]    n_act;

   always_comb begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
         esize[c]  = sizes_ff[c*SIZE_BITS +: SIZE_BITS];
         ecount[c] = counts_ff[c*CNT_BITS +: CNT_BITS];
      end
      if (classes_ff == 3'd0) begin
         n_act = (CLS_BITS+1)'(1);
      end else if (classes_ff > 3'(NUM_CLASSES)) begin
         n_act = (CLS_BITS+1)'(NUM_CLASSES);
      end else begin
         n_act = (CLS_BITS+1)'(classes_ff);
      end
   end

   // state
   state_type              state_ff;
   logic [CNT_BITS-1:0]    used_ff [NUM_CLASSES];
   logic [BASE_BITS-1:0]   base_ff [NUM_CLASSES+1];
   logic [CLS_BITS-1:0]    bj_ff;
   logic                   mode_ff;
   logic [SIZE_BITS-1:0]   rsize_ff;
   logic [ADDR_BITS-1:0]   addr_ff;
   logic [CLS_BITS-1:0]    cls_ff;
   logic [SIZE_BITS-1:0]   bsize_ff;
   logic [STAT_BITS-1:0]   stat_ff;
   logic [ADDR_BITS-1:0]   baddr_ff;
   logic [OFF_BITS-1:0]    prod_ff;
   logic [SLOT_BITS-1:0]   slot_ff;
   logic [SLOT_BITS-1:0]   idx_ff;
   logic                   pend_ff;
   logic                   seen_ff;
   logic                   rsp_vld_ff;
   logic [STAT_BITS-1:0]   o_stat_ff;
   logic [ADDR_BITS-1:0]   o_baddr_ff;
   logic [CLS_BITS-1:0]    o_cls_ff;
   logic [SIZE_BITS-1:0]   o_bsize_ff;
   logic [LIVE_BITS-1:0]   o_live_ff;
   logic [SIZE_BITS-1:0]   o_large_ff;

   // memory and divider
   mem_req_type            mem_req;
   logic [SLOT_BITS-1:0]   mem_q;
   logic                   init_done;
   logic                   div_start;
   logic [OFF_BITS-1:0]    div_dividend;
   logic                   div_done;
   logic [OFF_BITS-1:0]    div_quot;
   logic [SIZE_BITS-1:0]   div_rem;

   // per-class values of the selected class
   logic [CLS_BITS-1:0]  sel_cls;
   logic [SIZE_BITS-1:0] sel_size;
   logic [CNT_BITS-1:0]  sel_count;
   logic [CNT_BITS-1:0]  sel_used;
   logic [BASE_BITS-1:0] sel_base;
   logic [CNT_BITS-1:0]  sel_fc;

   scpa_stack_mem u_mem (
      .clock     (clock),
      .reset     (reset),
      .mem_req   (mem_req),
      .rd_data   (mem_q),
      .init_done (init_done)
   );

   scpa_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (sel_size),
      .done      (div_done),
      .quot      (div_quot),
      .remainder (div_rem)
   );

   // allocation class search
   logic                 a_found;
   logic [CLS_BITS-1:0]  a_cls;
   logic [SIZE_BITS-1:0] last_size;
   always_comb begin
      a_found   = 1'b0;
      a_cls     = '0;
      last_size = '0;
      for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
         if ((CLS_BITS+1)'(c) < n_act && rsize_ff <= esize[c] &&
             (!cascade_ff || used_ff[c] < ecount[c])) begin
            a_found = 1'b1;
            a_cls   = CLS_BITS'(c);
         end
         if ((CLS_BITS+1)'(c) == n_act - 1'b1) begin
            last_size = esize[c];
         end
      end
   end

   // free class search
   logic [BASE_BITS-1:0] heap_end;
   logic [CLS_BITS-1:0]  f_cls;
   logic                 f_hit;
   logic                 outside;
   always_comb begin
      heap_end = '0;
      f_cls    = '0;
      f_hit    = 1'b0;
      for (int c = 0; c <= NUM_CLASSES; c++) begin
         if ((CLS_BITS+1)'(c) == n_act) begin
            heap_end = base_ff[c];
         end
      end
      for (int c = 0; c < NUM_CLASSES - 1; c++) begin
         if (!f_hit && (CLS_BITS+1)'(c + 1) < n_act &&
             {2'b00, addr_ff} < base_ff[c+1]) begin
            f_hit = 1'b1;
            f_cls = CLS_BITS'(c);
         end
      end
      if (!f_hit) begin
         f_cls = CLS_BITS'(n_act - 1'b1);
      end
      outside = ({2'b00, addr_ff} < base_ff[0]) || ({2'b00, addr_ff} >= heap_end);
   end

   always_comb begin
      if (state_ff == S_DECIDE) begin
         sel_cls = (mode_ff == MODE_ALLOC) ? a_cls : f_cls;
      end else begin
         sel_cls = cls_ff;
      end
      sel_size  = '0;
      sel_count = '0;
      sel_used  = '0;
      sel_base  = '0;
      for (int c = 0; c < NUM_CLASSES; c++) begin
         if (CLS_BITS'(c) == sel_cls) begin
            sel_size  = esize[c];
            sel_count = ecount[c];
            sel_used  = used_ff[c];
            sel_base  = base_ff[c];
         end
      end
      sel_fc = (sel_count > sel_used) ? sel_count - sel_used : '0;
   end

   logic [BASE_BITS-1:0] f_off;
   assign f_off        = {2'b00, addr_ff} - sel_base;
   assign div_dividend = f_off[OFF_BITS-1:0];

   // summary figures over the updated counts
   logic [LIVE_BITS-1:0] live_sum;
   logic [SIZE_BITS-1:0] largest;
   always_comb begin
      live_sum = '0;
      largest  = '0;
      for (int c = 0; c < NUM_CLASSES; c++) begin
         live_sum = live_sum + LIVE_BITS'(used_ff[c]);
         if ((CLS_BITS+1)'(c) < n_act && ecount[c] > used_ff[c]) begin
            largest = esize[c];
         end
      end
   end

   logic seen_now;
   logic out_free;
   assign seen_now = seen_ff || (pend_ff && mem_q == slot_ff);
   assign out_free = !rsp_vld_ff || rsp_ch.ready;

   // memory port and divider start
   always_comb begin
      mem_req.we    = 1'b0;
      mem_req.addr  = {sel_cls, SLOT_BITS'(sel_count - sel_used - 1'b1)};
      mem_req.wdata = slot_ff;
      div_start     = 1'b0;
      case (state_ff)
         S_DECIDE: begin
            div_start = (mode_ff == MODE_FREE) && !outside && (sel_used != '0) &&
                        (sel_size != '0);
         end
         S_SCAN: begin
            mem_req.addr = {cls_ff, idx_ff};
         end
         S_PUSH: begin
            mem_req.we   = 1'b1;
            mem_req.addr = {cls_ff, sel_fc};
         end
         default: ;
      endcase
   end

   // control sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         rsp_vld_ff <= 1'b0;
         for (int c = 0; c < NUM_CLASSES; c++) begin
            used_ff[c] <= '0;
         end
      end else begin
         if (rsp_vld_ff && rsp_ch.ready && state_ff != S_DONE) begin
            rsp_vld_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_ch.valid && init_done) begin
                  mode_ff    <= req_ch.mode;
                  rsize_ff   <= req_ch.request_size;
                  addr_ff    <= req_ch.address;
                  base_ff[0] <= {2'b00, heap_base_ff};
                  bj_ff      <= '0;
                  state_ff   <= S_BASE;
               end
            end
            S_BASE: begin
               for (int c = 0; c < NUM_CLASSES; c++) begin
                  if (CLS_BITS'(c) == bj_ff) begin
                     base_ff[c+1] <= base_ff[c] +
                                     BASE_BITS'(esize[c]) * BASE_BITS'(ecount[c]);
                  end
               end
               bj_ff <= bj_ff + 1'b1;
               if (bj_ff == CLS_BITS'(NUM_CLASSES - 1)) begin
                  state_ff <= S_DECIDE;
               end
            end
            S_DECIDE: begin
               baddr_ff <= '0;
               if (mode_ff == MODE_ALLOC) begin
                  if (!a_found) begin
                     stat_ff  <= (rsize_ff > last_size) ? ST_TOO_LARGE : ST_FULL;
                     cls_ff   <= '0;
                     bsize_ff <= '0;
                     state_ff <= S_DONE;
                  end else begin
                     cls_ff   <= sel_cls;
                     bsize_ff <= sel_size;
                     if (sel_used >= sel_count) begin
                        stat_ff  <= ST_FULL;
                        state_ff <= S_DONE;
                     end else begin
                        stat_ff <= ST_OK;
                        for (int c = 0; c < NUM_CLASSES; c++) begin
                           if (CLS_BITS'(c) == sel_cls) begin
                              used_ff[c] <= used_ff[c] + 1'b1;
                           end
                        end
                        state_ff <= S_AMUL;
                     end
                  end
               end else begin
                  if (outside) begin
                     stat_ff  <= ST_OUTSIDE;
                     cls_ff   <= '0;
                     bsize_ff <= '0;
                     state_ff <= S_DONE;
                  end else begin
                     cls_ff   <= sel_cls;
                     bsize_ff <= sel_size;
                     if (sel_used == '0) begin
                        stat_ff  <= ST_EMPTY;
                        state_ff <= S_DONE;
                     end else if (sel_size == '0) begin
                        stat_ff  <= ST_MISALIGNED;
                        state_ff <= S_DONE;
                     end else begin
                        state_ff <= S_DIV;
                     end
                  end
               end
            end
            S_AMUL: begin
               prod_ff  <= OFF_BITS'(mem_q) * OFF_BITS'(bsize_ff);
               state_ff <= S_AADD;
            end
            S_AADD: begin
               baddr_ff <= ADDR_BITS'(sel_base + BASE_BITS'(prod_ff));
               state_ff <= S_DONE;
            end
            S_DIV: begin
               if (div_done) begin
                  slot_ff <= div_quot[SLOT_BITS-1:0];
                  idx_ff  <= '0;
                  pend_ff <= 1'b0;
                  seen_ff <= 1'b0;
                  if (div_rem != '0) begin
                     stat_ff  <= ST_MISALIGNED;
                     state_ff <= S_DONE;
                  end else begin
                     state_ff <= S_SCAN;
                  end
               end
            end
            S_SCAN: begin
               seen_ff <= seen_now;
               if (idx_ff != sel_fc) begin
                  idx_ff  <= idx_ff + 1'b1;
                  pend_ff <= 1'b1;
               end else begin
                  pend_ff <= 1'b0;
                  if (!pend_ff) begin
                     if (seen_ff) begin
                        stat_ff  <= ST_DOUBLE;
                        state_ff <= S_DONE;
                     end else begin
                        state_ff <= S_PUSH;
                     end
                  end
               end
            end
            S_PUSH: begin
               stat_ff <= ST_OK;
               for (int c = 0; c < NUM_CLASSES; c++) begin
                  if (CLS_BITS'(c) == cls_ff) begin
                     used_ff[c] <= used_ff[c] - 1'b1;
                  end
               end
               state_ff <= S_DONE;
            end
            S_DONE: begin
               if (out_free) begin
                  rsp_vld_ff <= 1'b1;
                  o_stat_ff  <= stat_ff;
                  o_baddr_ff <= baddr_ff;
                  o_cls_ff   <= cls_ff;
                  o_bsize_ff <= bsize_ff;
                  o_live_ff  <= live_sum;
                  o_large_ff <= largest;
                  state_ff   <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // ports
   assign req_ch.ready             = (state_ff == S_IDLE) && init_done;
   assign rsp_ch.valid             = rsp_vld_ff;
   assign rsp_ch.status            = o_stat_ff;
   assign rsp_ch.block_address     = o_baddr_ff;
   assign rsp_ch.size_class        = o_cls_ff;
   assign rsp_ch.block_size        = o_bsize_ff;
   assign rsp_ch.live_allocations  = o_live_ff;
   assign rsp_ch.largest_free_size = o_large_ff;

   // checks
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      !init_done |-> !req_ch.ready)
      else $error("word accepted during stack clearing");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
      else $error("second word accepted while busy");

   a_no_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> !mem_req.we)
      else $error("stack written during double-free scan");

   a_ok_alloc_nonzero_class: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_AADD) |-> (stat_ff == ST_OK))
      else $error("address computed for a failed allocation");

endmodule

/* src/scpa_divider.sv */
// -----------------------------------------------------------------------------
// scpa_divider
// Restoring divider, one quotient bit per cycle, for slot offset / size.
// -----------------------------------------------------------------------------
module scpa_divider (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [scpa_pkg::OFF_BITS-1:0]   dividend,
   input  logic [scpa_pkg::SIZE_BITS-1:0]  divisor,
   output logic                            done,
   output logic [scpa_pkg::OFF_BITS-1:0]   quot,
   output logic [scpa_pkg::SIZE_BITS-1:0]  remainder
);
   import scpa_pkg::*;

   localparam int STEP_BITS = $clog2(OFF_BITS + 1);

   logic [STEP_BITS-1:0] cnt_ff, cnt_in;
   logic                 done_ff, done_in;
   logic [OFF_BITS-1:0]  q_ff, q_in;
   logic [SIZE_BITS-1:0] r_ff, r_in;
   logic [SIZE_BITS-1:0] d_ff, d_in;
   logic [SIZE_BITS:0]   trial;

   // one shift-subtract step per cycle
   always_comb begin
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      q_in    = q_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      trial   = {r_ff, q_ff[OFF_BITS-1]};
      if (start) begin
         cnt_in = STEP_BITS'(OFF_BITS);
         q_in   = dividend;
         r_in   = '0;
         d_in   = divisor;
      end else if (cnt_ff != '0) begin
         if (trial >= {1'b0, d_ff}) begin
            r_in = SIZE_BITS'(trial - {1'b0, d_ff});
            q_in = {q_ff[OFF_BITS-2:0], 1'b1};
         end else begin
            r_in = trial[SIZE_BITS-1:0];
            q_in = {q_ff[OFF_BITS-2:0], 1'b0};
         end
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == STEP_BITS'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
   end

   assign done      = done_ff;
   assign quot      = q_ff;
   assign remainder = r_ff;

endmodule

/* src/scpa_stack_mem.sv */
// -----------------------------------------------------------------------------
// scpa_stack_mem
// Free-slot stack memory of all classes, with a clearing pass after reset
// that loads every entry with its slot index.
// -----------------------------------------------------------------------------
module scpa_stack_mem (
   input  logic                           clock,
   input  logic                           reset,
   input  scpa_pkg::mem_req_type          mem_req,
   output logic [scpa_pkg::SLOT_BITS-1:0] rd_data,
   output logic                           init_done
);
   import scpa_pkg::*;

   logic [SLOT_BITS-1:0] mem [MEM_DEPTH];
   logic [MEM_ABITS:0]   clr_ff, clr_in;
   logic [SLOT_BITS-1:0] rd_ff;
   logic                 busy;

   assign busy   = !clr_ff[MEM_ABITS];
   assign clr_in = busy ? clr_ff + 1'b1 : clr_ff;

   // clearing counter
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else begin
         clr_ff <= clr_in;
      end
   end

   // array with one write and one read port, registered read
   always_ff @(posedge clock) begin
      if (busy) begin
         mem[clr_ff[MEM_ABITS-1:0]] <= clr_ff[SLOT_BITS-1:0];
      end else if (mem_req.we) begin
         mem[mem_req.addr] <= mem_req.wdata;
      end
      rd_ff <= mem[mem_req.addr];
   end

   assign rd_data   = rd_ff;
   assign init_done = !busy;

endmodule

/* sim/scpa_checker.sv */
// -----------------------------------------------------------------------------
// scpa_checker
// Watches the request, response and register ports of the pool allocator,
// keeps its own copy of the class state and checks every response word.
// -----------------------------------------------------------------------------
module scpa_checker (
   input  logic        clock,
   input  logic        reset,
   scpa_req_if         req_ch,
   scpa_rsp_if         rsp_ch,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata,
   output int          fail_count,
   output int          pending
);
   import scpa_pkg::*;

   typedef struct {
      logic [2:0]  status;
      logic [31:0] block_address;
      logic [1:0]  size_class;
      logic [15:0] block_size;
      logic [9:0]  live_allocations;
      logic [15:0] largest_free_size;
   } outcome_type;

   // shadow registers
   logic [2:0]  classes_reg;
   logic        cascade_reg;
   logic [31:0] base_reg;
   logic [63:0] sizes_reg;
   logic [31:0] counts_reg;

   // shadow allocator state
   int         used_cnt [NUM_CLASSES];
   logic [7:0] slot_stack [MEM_DEPTH];

   outcome_type expected_q [$];

   function automatic int active_count();
      if (classes_reg == 0) return 1;
      if (classes_reg > NUM_CLASSES) return NUM_CLASSES;
      return int'(classes_reg);
   endfunction

   function automatic logic [63:0] elem_bytes(int c);
      return 64'(sizes_reg[16*c +: 16]);
   endfunction

   function automatic int elem_total(int c);
      int k;
      k = int'(counts_reg[8*c +: 8]);
      if (k > SLOTS_PER_CLASS) k = SLOTS_PER_CLASS;
      return k;
   endfunction

   // class bases add up without wrapping
   function automatic logic [63:0] region_start(int c);
      logic [63:0] b;
      b = 64'(base_reg);
      for (int j = 0; j < c; j++) b += elem_bytes(j) * 64'(elem_total(j));
      return b;
   endfunction

   function automatic outcome_type allocate_or_free(logic mode, logic [15:0] req_size,
                                                    logic [31:0] addr);
      outcome_type o;
      int          n, c, pos, fc;
      logic [63:0] a, off, top, live;
      logic [7:0]  slot;
      bit          seen;
      n = active_count();
      o.status = ST_OK; o.block_address = '0; o.size_class = '0; o.block_size = '0;
      if (mode == MODE_ALLOC) begin
         for (c = 0; c < n; c++)
            if (64'(req_size) <= elem_bytes(c) &&
                (!cascade_reg || used_cnt[c] < elem_total(c))) break;
         if (c >= n) begin
            o.status = (64'(req_size) > elem_bytes(n-1)) ? ST_TOO_LARGE : ST_FULL;
         end else begin
            o.size_class = 2'(c);
            o.block_size = 16'(elem_bytes(c));
            if (used_cnt[c] >= elem_total(c)) begin
               o.status = ST_FULL;
            end else begin
               used_cnt[c]++;
               pos = elem_total(c) - used_cnt[c];
               o.block_address = 32'(region_start(c) +
                  64'(slot_stack[c*SLOTS_PER_CLASS + pos]) * elem_bytes(c));
            end
         end
      end else begin
         a   = 64'(addr);
         top = region_start(n-1) + elem_bytes(n-1) * 64'(elem_total(n-1));
         if (a < region_start(0) || a >= top) begin
            o.status = ST_OUTSIDE;
         end else begin
            for (c = 0; c + 1 < n; c++)
               if (a < region_start(c+1)) break;
            o.size_class = 2'(c);
            o.block_size = 16'(elem_bytes(c));
            if (used_cnt[c] == 0) begin
               o.status = ST_EMPTY;
            end else begin
               off = a - region_start(c);
               if (elem_bytes(c) == 0 || off % elem_bytes(c) != 0) begin
                  o.status = ST_MISALIGNED;
               end else begin
                  slot = 8'(off / elem_bytes(c));
                  fc   = (elem_total(c) > used_cnt[c]) ? elem_total(c) - used_cnt[c] : 0;
                  seen = 0;
                  for (int i = 0; i < fc; i++)
                     if (slot_stack[c*SLOTS_PER_CLASS + i] == slot) seen = 1;
                  if (seen) begin
                     o.status = ST_DOUBLE;
                  end else begin
                     slot_stack[c*SLOTS_PER_CLASS + fc] = slot;
                     used_cnt[c]--;
                  end
               end
            end
         end
      end
      live = '0;
      for (c = 0; c < NUM_CLASSES; c++) live += 64'(used_cnt[c]);
      o.live_allocations  = 10'(live);
      o.largest_free_size = '0;
      for (c = n; c > 0; c--)
         if (elem_total(c-1) > used_cnt[c-1]) begin
            o.largest_free_size = 16'(elem_bytes(c-1));
            break;
         end
      return o;
   endfunction

   always @(posedge clock) begin
      outcome_type e;
      if (reset) begin
         classes_reg <= 3'd4; cascade_reg <= 1'b0; base_reg <= '0;
         sizes_reg <= SIZES_RESET; counts_reg <= COUNTS_RESET;
         for (int c = 0; c < NUM_CLASSES; c++) begin
            used_cnt[c] = 0;
            for (int k = 0; k < SLOTS_PER_CLASS; k++)
               slot_stack[c*SLOTS_PER_CLASS + k] = 8'(k);
         end
         expected_q.delete();
         fail_count = 0;
      end else begin
         // register writes
         if (csr_wr_en) begin
            case (csr_index)
               CSR_CLASSES: classes_reg <= csr_wdata[2:0];
               CSR_CASCADE: cascade_reg <= csr_wdata[0];
               CSR_BASE:    base_reg    <= csr_wdata[31:0];
               CSR_SIZES:   sizes_reg   <= csr_wdata;
               CSR_COUNTS:  counts_reg  <= csr_wdata[31:0];
               default: ;
            endcase
         end
         // compare a response word before taking a new request
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_q.size() == 0) begin
               $display("%0t: response word with nothing expected, status %0d",
                        $time, rsp_ch.status);
               fail_count++;
            end else begin
               e = expected_q.pop_front();
               if (rsp_ch.status !== e.status) begin
                  $display("%0t: status exp %0d got %0d", $time, e.status, rsp_ch.status);
                  fail_count++;
               end
               if (rsp_ch.block_address !== e.block_address) begin
                  $display("%0t: block_address exp %h got %h", $time,
                           e.block_address, rsp_ch.block_address);
                  fail_count++;
               end
               if (rsp_ch.size_class !== e.size_class) begin
                  $display("%0t: size_class exp %0d got %0d", $time,
                           e.size_class, rsp_ch.size_class);
                  fail_count++;
               end
               if (rsp_ch.block_size !== e.block_size) begin
                  $display("%0t: block_size exp %0d got %0d", $time,
                           e.block_size, rsp_ch.block_size);
                  fail_count++;
               end
               if (rsp_ch.live_allocations !== e.live_allocations) begin
                  $display("%0t: live_allocations exp %0d got %0d", $time,
                           e.live_allocations, rsp_ch.live_allocations);
                  fail_count++;
               end
               if (rsp_ch.largest_free_size !== e.largest_free_size) begin
                  $display("%0t: largest_free_size exp %0d got %0d", $time,
                           e.largest_free_size, rsp_ch.largest_free_size);
                  fail_count++;
               end
            end
         end
         if (req_ch.valid && req_ch.ready)
            expected_q.push_back(allocate_or_free(req_ch.mode, req_ch.request_size,
                                                  req_ch.address));
      end
      pending = expected_q.size();
   end

endmodule

/* sim/tb.sv */
// -----------------------------------------------------------------------------
// tb
// Drives the pool allocator through several class layouts with directed and
// random allocate/free words under bursty sending and a stalling receiver.
// -----------------------------------------------------------------------------
module tb;
   import scpa_pkg::*;

   localparam int CYCLE_LIMIT = 3000000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [63:0] csr_wdata = '0;
   int          fail_count, pending;
   int          cycles = 0;
   int          ready_pct = 100;
   int          max_size = 128;
   logic [31:0] heap_lo = '0;
   logic [31:0] live_addrs [$];
   logic [31:0] freed_addrs [$];

   scpa_req_if req_ch ();
   scpa_rsp_if rsp_ch ();

   size_class_pool_allocator_top u_dut (
      .clock(clock), .reset(reset), .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   scpa_checker u_chk (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .pending(pending)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // cycle limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // receiver stalls, under a ready percentage that is redrawn periodically and at times set back to full
   always @(posedge clock) begin
      if (cycles % 700 == 0) ready_pct <= (cycles % 2100 == 0) ? 100 :
                                          $urandom_range(20, 90);
      rsp_ch.ready <= ($urandom_range(1, 100) <= ready_pct);
   end

   // remember addresses that were handed out
   always @(posedge clock)
      if (rsp_ch.valid && rsp_ch.ready && rsp_ch.status == ST_OK && rsp_ch.block_address != 0)
         live_addrs.push_back(rsp_ch.block_address);

   int burst_left = 0;

   // one word, held until the block takes it
   task automatic send_word(logic mode, logic [15:0] size, logic [31:0] addr);
      if (burst_left == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      req_ch.valid        <= 1'b1;
      req_ch.mode         <= mode;
      req_ch.request_size <= size;
      req_ch.address      <= addr;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic csr_write(logic [2:0] idx, logic [63:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   // wait for every response, then let the block settle
   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic setup(logic [2:0] ncls, logic casc, logic [31:0] base,
                        logic [63:0] sizes, logic [31:0] counts);
      drain();
      csr_write(CSR_CLASSES, 64'(ncls));
      csr_write(CSR_CASCADE, 64'(casc));
      csr_write(CSR_BASE, 64'(base));
      csr_write(CSR_SIZES, sizes);
      csr_write(CSR_COUNTS, 64'(counts));
      csr_wr_en <= 1'b0;
      @(posedge clock);
      heap_lo  = base;
      max_size = 0;
      for (int c = 0; c < NUM_CLASSES; c++)
         if (sizes[16*c +: 16] > max_size) max_size = sizes[16*c +: 16];
      live_addrs.delete();
      freed_addrs.delete();
   endtask

   // random word: mostly frees of real blocks and fitting allocations
   task automatic random_words(int count);
      int          pick, idx;
      logic [31:0] a;
      repeat (count) begin
         pick = $urandom_range(0, 99);
         if (pick < 50) begin
            if ($urandom_range(0, 9) == 0) send_word(MODE_ALLOC, 16'($urandom), '0);
            else send_word(MODE_ALLOC, 16'($urandom_range(0, max_size + max_size/8 + 1)),
                           $urandom);
         end else if (pick < 80 && live_addrs.size() != 0) begin
            idx = $urandom_range(0, live_addrs.size() - 1);
            a = live_addrs[idx];
            live_addrs.delete(idx);
            freed_addrs.push_back(a);
            send_word(MODE_FREE, 16'($urandom), a);
         end else if (pick < 87 && freed_addrs.size() != 0) begin
            send_word(MODE_FREE, '0, freed_addrs[$urandom_range(0, freed_addrs.size() - 1)]);
         end else if (pick < 93) begin
            a = heap_lo + $urandom_range(0, 4 * max_size * 64 + 8);
            send_word(MODE_FREE, '0, a);
         end else begin
            send_word(MODE_FREE, '0, $urandom);
         end
      end
   endtask

   initial begin
      req_ch.valid = 1'b0; req_ch.mode = MODE_ALLOC;
      req_ch.request_size = '0; req_ch.address = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset layout: classes of 16, 32, 64 and 128 bytes, 64 of each
      send_word(MODE_ALLOC, 16'd0, '0);
      send_word(MODE_ALLOC, 16'd16, '0);
      send_word(MODE_ALLOC, 16'd17, '0);
      send_word(MODE_ALLOC, 16'd128, '0);
      send_word(MODE_ALLOC, 16'd129, '0);
      send_word(MODE_ALLOC, 16'hFFFF, '0);
      send_word(MODE_FREE, 16'hFFFF, 32'd1008);
      send_word(MODE_FREE, '0, 32'd1008);
      send_word(MODE_FREE, '0, 32'd1009);
      send_word(MODE_FREE, '0, 32'hFFFF_FFFF);
      send_word(MODE_FREE, '0, 32'd3072);
      send_word(MODE_FREE, '0, 32'd0);
      send_word(MODE_FREE, '0, 32'd8192);
      repeat (30) send_word(MODE_ALLOC, 16'd100, '0);
      send_word(MODE_ALLOC, 16'd1, '0);
      random_words(300);

      // small classes with cascading, full classes come up often
      setup(3'd4, 1'b1, 32'h0000_1000, {16'd128, 16'd64, 16'd32, 16'd16}, 32'h0208_0304);
      random_words(400);
      // count zero acts as one class, heap runs past the address space
      setup(3'd0, 1'b0, 32'hFFFF_FF00, {16'd4, 16'd3, 16'd2, 16'h0040}, 32'h0101_0108);
      random_words(200);
      // count above the maximum, odd sizes including zero, counts shrunk under use
      setup(3'd7, 1'b1, $urandom, {16'd48, 16'd0, 16'd20, 16'd12}, 32'h0500_0306);
      random_words(350);
      // largest sizes and counts
      setup(3'd2, 1'b0, 32'h0, {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h8000}, 32'hFFFF_FFFF);
      random_words(150);
      // zero-size first class, empty class, cascading on
      setup(3'd3, 1'b1, 32'h8000_0000, {16'd200, 16'd40, 16'd24, 16'd0}, 32'h0A05_0004);
      random_words(300);
      // random layout
      setup(3'($urandom_range(1, 4)), 1'($urandom), $urandom,
            {16'($urandom_range(257, 1024)), 16'($urandom_range(65, 256)),
             16'($urandom_range(17, 64)), 16'($urandom_range(1, 16))}, $urandom & 32'h0F0F_0F0F);
      random_words(300);

      drain();
      if (fail_count == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule

/* filelist.f */
src/scpa_pkg.sv
src/scpa_if.sv
src/scpa_divider.sv
src/scpa_stack_mem.sv
src/size_class_pool_allocator_top.sv
sim/scpa_checker.sv
sim/tb.sv
